// ----- hdl/cbdsd_pkg.sv -----
// Shared types, constants and address decode for the console bus block.
// Depends on nothing; used by console_bus_decode_sprite_dma.
package cbdsd_pkg;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      TGT_NONE = 3'd0,
      TGT_CART = 3'd1,
      TGT_RAM  = 3'd2,
      TGT_PPU  = 3'd3,
      TGT_PAD  = 3'd4,
      TGT_DMA  = 3'd5
   } target_type;

   localparam logic [15:0] RAM_LAST   = 16'h1FFF;
   localparam logic [15:0] PPU_FIRST  = 16'h2000;
   localparam logic [15:0] PPU_LAST   = 16'h3FFF;
   localparam logic [15:0] DMA_REG    = 16'h4014;
   localparam logic [15:0] PAD_ZERO   = 16'h4016;
   localparam logic [15:0] PAD_ONE    = 16'h4017;
   localparam logic [2:0]  PHASE_LAST = 3'd5;
   localparam logic [2:0]  PHASE_A    = 3'd0;
   localparam logic [2:0]  PHASE_B    = 3'd3;

   function automatic target_type decode(input logic [15:0] addr, input logic cart);
      target_type t;
      if (cart) begin
         t = TGT_CART;
      end else if (addr <= RAM_LAST) begin
         t = TGT_RAM;
      end else if (addr >= PPU_FIRST && addr <= PPU_LAST) begin
         t = TGT_PPU;
      end else if (addr == PAD_ZERO || addr == PAD_ONE) begin
         t = TGT_PAD;
      end else begin
         t = TGT_NONE;
      end
      return t;
   endfunction

endpackage

// ----- hdl/console_bus_decode_sprite_dma.sv -----
// Console system bus: address decode, controller ports, clock phase and sprite DMA.
// Depends on cbdsd_pkg for operation and target codes and the decode function.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  operation, address, data, buttons, nmi
//   rsp_      out        rsp_valid/rsp_stall  target, read data, step, DMA and OAM, nmi
//
// Each request is held first in the input register, then goes through the decode and
// state update into the response register.
// Unless the response stalls, a new request can be accepted every cycle.
// A stalled response holds the input register, and the request side then stalls.
// Reset is synchronous and active high; the DMA starts idle with its wait armed.
module console_bus_decode_sprite_dma (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic        req_cart_hit,
   input  logic [7:0]  req_pad_zero_buttons,
   input  logic [7:0]  req_pad_one_buttons,
   input  logic [7:0]  req_bus_return_data,
   input  logic        req_ppu_nmi,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_target,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_cpu_step,
   output logic        rsp_dma_read_request,
   output logic [15:0] rsp_dma_read_address,
   output logic        rsp_oam_write,
   output logic [7:0]  rsp_oam_address,
   output logic [7:0]  rsp_oam_data,
   output logic        rsp_cpu_nmi
);
   import cbdsd_pkg::*;

   logic        s1_valid_ff;
   logic [1:0]  s1_op_ff;
   logic [15:0] s1_addr_ff;
   logic [7:0]  s1_wdata_ff;
   logic        s1_cart_ff;
   logic [7:0]  s1_pad0_ff;
   logic [7:0]  s1_pad1_ff;
   logic [7:0]  s1_ret_ff;
   logic        s1_nmi_ff;

   logic        out_valid_ff;
   logic [2:0]  out_target_ff, out_target_in;
   logic [7:0]  out_rdata_ff, out_rdata_in;
   logic        out_step_ff, out_step_in;
   logic        out_rreq_ff, out_rreq_in;
   logic [15:0] out_raddr_ff, out_raddr_in;
   logic        out_oamw_ff, out_oamw_in;
   logic [7:0]  out_oama_ff, out_oama_in;
   logic [7:0]  out_oamd_ff, out_oamd_in;
   logic        out_nmi_ff, out_nmi_in;

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  page_ff, page_in;
   logic [7:0]  offset_ff, offset_in;
   logic [7:0]  byte_ff, byte_in;
   logic        active_ff, active_in;
   logic        waiting_ff, waiting_in;
   logic        pending_ff, pending_in;
   logic [7:0]  shift0_ff, shift0_in;
   logic [7:0]  shift1_ff, shift1_in;

   logic        advance;
   logic        port_sel;
   logic [7:0]  shift_sel;
   target_type  tgt;

   assign advance   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign port_sel  = s1_addr_ff[0];
   assign shift_sel = port_sel ? shift1_ff : shift0_ff;
   assign tgt       = decode(s1_addr_ff, s1_cart_ff);

   always_comb begin
      phase_in      = phase_ff;
      page_in       = page_ff;
      offset_in     = offset_ff;
      byte_in       = byte_ff;
      active_in     = active_ff;
      waiting_in    = waiting_ff;
      pending_in    = pending_ff;
      shift0_in     = shift0_ff;
      shift1_in     = shift1_ff;
      out_target_in = TGT_NONE;
      out_rdata_in  = 8'd0;
      out_step_in   = 1'b0;
      out_rreq_in   = 1'b0;
      out_raddr_in  = 16'd0;
      out_oamw_in   = 1'b0;
      out_oama_in   = 8'd0;
      out_oamd_in   = 8'd0;
      out_nmi_in    = 1'b0;
      unique case (s1_op_ff)
         OP_TICK: begin
            if (pending_ff) begin
               byte_in    = s1_ret_ff;
               pending_in = 1'b0;
            end
            if (phase_ff == PHASE_A || phase_ff == PHASE_B) begin
               if (!active_ff) begin
                  out_step_in = 1'b1;
               end else if (waiting_ff) begin
                  if (phase_ff == PHASE_B) begin
                     waiting_in = 1'b0;
                  end
               end else if (phase_ff == PHASE_A) begin
                  out_rreq_in  = 1'b1;
                  out_raddr_in = {page_ff, offset_ff};
                  pending_in   = 1'b1;
               end else begin
                  out_oamw_in = 1'b1;
                  out_oama_in = offset_ff;
                  out_oamd_in = byte_in;
                  offset_in   = offset_ff + 8'd1;
                  if (offset_ff == 8'hFF) begin
                     active_in  = 1'b0;
                     waiting_in = 1'b1;
                  end
               end
            end
            out_nmi_in = s1_nmi_ff;
            phase_in   = (phase_ff >= PHASE_LAST) ? 3'd0 : phase_ff + 3'd1;
         end
         OP_READ: begin
            out_target_in = tgt;
            if (tgt == TGT_PAD) begin
               out_rdata_in = {7'd0, shift_sel[7]};
               if (port_sel) begin
                  shift1_in = {shift1_ff[6:0], 1'b0};
               end else begin
                  shift0_in = {shift0_ff[6:0], 1'b0};
               end
            end
         end
         OP_WRITE: begin
            out_target_in = tgt;
            if (tgt == TGT_NONE && s1_addr_ff == DMA_REG) begin
               out_target_in = TGT_DMA;
               page_in       = s1_wdata_ff;
               offset_in     = 8'd0;
               active_in     = 1'b1;
            end else if (tgt == TGT_PAD) begin
               if (port_sel) begin
                  shift1_in = s1_pad1_ff;
               end else begin
                  shift0_in = s1_pad0_ff;
               end
            end
         end
         default: begin
            out_target_in = TGT_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= 3'd0;
         page_ff      <= 8'd0;
         offset_ff    <= 8'd0;
         byte_ff      <= 8'd0;
         active_ff    <= 1'b0;
         waiting_ff   <= 1'b1;
         pending_ff   <= 1'b0;
         shift0_ff    <= 8'd0;
         shift1_ff    <= 8'd0;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            page_ff      <= page_in;
            offset_ff    <= offset_in;
            byte_ff      <= byte_in;
            active_ff    <= active_in;
            waiting_ff   <= waiting_in;
            pending_ff   <= pending_in;
            shift0_ff    <= shift0_in;
            shift1_ff    <= shift1_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         s1_op_ff    <= req_operation;
         s1_addr_ff  <= req_address;
         s1_wdata_ff <= req_write_data;
         s1_cart_ff  <= req_cart_hit;
         s1_pad0_ff  <= req_pad_zero_buttons;
         s1_pad1_ff  <= req_pad_one_buttons;
         s1_ret_ff   <= req_bus_return_data;
         s1_nmi_ff   <= req_ppu_nmi;
      end
      if (advance) begin
         out_target_ff <= out_target_in;
         out_rdata_ff  <= out_rdata_in;
         out_step_ff   <= out_step_in;
         out_rreq_ff   <= out_rreq_in;
         out_raddr_ff  <= out_raddr_in;
         out_oamw_ff   <= out_oamw_in;
         out_oama_ff   <= out_oama_in;
         out_oamd_ff   <= out_oamd_in;
         out_nmi_ff    <= out_nmi_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_target           = out_target_ff;
   assign rsp_read_data        = out_rdata_ff;
   assign rsp_cpu_step         = out_step_ff;
   assign rsp_dma_read_request = out_rreq_ff;
   assign rsp_dma_read_address = out_raddr_ff;
   assign rsp_oam_write        = out_oamw_ff;
   assign rsp_oam_address      = out_oama_ff;
   assign rsp_oam_data         = out_oamd_ff;
   assign rsp_cpu_nmi          = out_nmi_ff;

endmodule
